// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine: request codes,
// status codes and the fixed field widths of the request and response.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int REQ_W     = 2;
	localparam int POS_W     = 8;
	localparam int VAL_W     = 32;
	localparam int ST_W      = 2;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_READ   = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_type_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

// ===== rtl/ple_req_if.sv =====
// ----------------------------------------------------------------------------
// ple_req_if
// Request channel of the positional list engine: valid/ready handshake with
// request type, target position and insert value.
// ----------------------------------------------------------------------------
interface ple_req_if;
	import ple_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] in_value;

	modport source (output valid, output req_type, output position, output in_value,
		input ready);
	modport sink (input valid, input req_type, input position, input in_value,
		output ready);

endinterface

// ===== rtl/ple_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ple_rsp_if
// Response channel of the positional list engine: valid/ready handshake with
// status, read value and entry count.
// ----------------------------------------------------------------------------
interface ple_rsp_if;
	import ple_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic signed [VAL_W-1:0] out_value;
	logic [CNT_OUT_W-1:0]    list_count;

	modport source (output valid, output status, output out_value, output list_count,
		input ready);
	modport sink (input valid, input status, input out_value, input list_count,
		output ready);

endinterface

// ===== rtl/ple_ram.sv =====
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values addressed by 1-based
// position: insert, read, delete and clear, one response per request.
//
//   channel  dir  payload                              transfer when
//   req      in   req_type, position, in_value         req.valid & req.ready
//   rsp      out  status, out_value, list_count        rsp.valid & rsp.ready
//
// insert and delete shift the entries from the position on one entry per cycle
// through the single write port of the list RAM; clear or a rejected request
// goes straight to done; the done state holds while a previous response waits.
// req.ready is high only in the idle state, one request at a time.
// the entry count clears on arst_n; list contents are undefined until written.
// a response waiting in the output register does not block the next request.
// ----------------------------------------------------------------------------
module positional_list_engine #(
	parameter int LIST_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	ple_req_if.sink    req,
	ple_rsp_if.source  rsp
);
	import ple_pkg::*;

	localparam int ADDR_W = $clog2(LIST_DEPTH);
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_INS_SH  = 6'b000010,
		S_INS_PUT = 6'b000100,
		S_DEL_SH  = 6'b001000,
		S_RD_WAIT = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [ADDR_W-1:0]       k_q, k_d;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] val_q;
	status_t                 status_q, status_d;
	logic signed [VAL_W-1:0] res_q;

	logic                    o_valid_q;
	status_t                 o_status_q;
	logic signed [VAL_W-1:0] o_value_q;
	logic [CNT_OUT_W-1:0]    o_count_q;

	logic                    req_fire;
	logic                    rsp_load;
	logic [CMP_W-1:0]        pos_x, posq_x, cnt_x, k_x;
	logic [ADDR_W-1:0]       pos_m1;
	logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
	logic [VAL_W-1:0]        ram_wdata, ram_rdata;

	ple_ram #(
		.WIDTH(VAL_W),
		.DEPTH(LIST_DEPTH)
	) u_list_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;

	assign pos_x   = CMP_W'(req.position);
	assign posq_x  = CMP_W'(pos_q);
	assign cnt_x   = CMP_W'(cnt_q);
	assign k_x     = CMP_W'(k_q);
	assign pos_m1  = ADDR_W'(posq_x - CMP_W'(1));
	assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_q};

	assign rsp.valid      = o_valid_q;
	assign rsp.status     = o_status_q;
	assign rsp.out_value  = o_value_q;
	assign rsp.list_count = o_count_q;

	// sequencer
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		k_d       = k_q;
		status_d  = ST_DONE;
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = ram_rdata;
		ram_raddr = k_q;
		rsp_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					case (req_type_t'(req.req_type))
						REQ_INSERT: begin
							if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
								status_d = ST_RANGE;
								state_d  = S_DONE;
							end else if (cnt_x == CMP_W'(LIST_DEPTH)) begin
								status_d = ST_FULL;
								state_d  = S_DONE;
							end else begin
								k_d = ADDR_W'(cnt_q);
								if (cnt_x >= pos_x) begin
									ram_raddr = ADDR_W'(cnt_x - CMP_W'(1));
									state_d   = S_INS_SH;
								end else begin
									state_d = S_INS_PUT;
								end
							end
						end
						REQ_READ: begin
							if (pos_x == '0 || pos_x > cnt_x) begin
								status_d = ST_RANGE;
								state_d  = S_DONE;
							end else begin
								ram_raddr = ADDR_W'(pos_x - CMP_W'(1));
								state_d   = S_RD_WAIT;
							end
						end
						REQ_DELETE: begin
							if (pos_x == '0 || pos_x > cnt_x) begin
								status_d = ST_RANGE;
								state_d  = S_DONE;
							end else if (pos_x == cnt_x) begin
								cnt_d   = cnt_q - CNT_W'(1);
								state_d = S_DONE;
							end else begin
								k_d       = ADDR_W'(pos_x);
								ram_raddr = ADDR_W'(pos_x);
								state_d   = S_DEL_SH;
							end
						end
						default: begin
							cnt_d   = '0;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_INS_SH: begin
				// move entry k-1 up to k, prefetch the next one down
				ram_we    = 1'b1;
				ram_waddr = k_q;
				ram_wdata = ram_rdata;
				if (k_x > posq_x) begin
					ram_raddr = ADDR_W'(k_x - CMP_W'(2));
					k_d       = ADDR_W'(k_x - CMP_W'(1));
				end else begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_m1;
				ram_wdata = val_q;
				cnt_d     = cnt_q + CNT_W'(1);
				state_d   = S_DONE;
			end
			S_DEL_SH: begin
				// move entry k down to k-1, prefetch the next one up
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(k_x - CMP_W'(1));
				ram_wdata = ram_rdata;
				if (k_x + CMP_W'(1) < cnt_x) begin
					ram_raddr = ADDR_W'(k_x + CMP_W'(1));
					k_d       = ADDR_W'(k_x + CMP_W'(1));
				end else begin
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = S_DONE;
				end
			end
			S_RD_WAIT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!o_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (rsp_load) begin
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q <= k_d;
		if (req_fire) begin
			pos_q    <= req.position;
			val_q    <= req.in_value;
			status_q <= status_d;
			res_q    <= '0;
		end
		if (state_q == S_RD_WAIT) begin
			res_q <= ram_rdata;
		end
		if (rsp_load) begin
			o_status_q <= status_q;
			o_value_q  <= res_q;
			o_count_q  <= cnt_ext[CNT_OUT_W-1:0];
		end
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= CMP_W'(LIST_DEPTH))
		else $error("entry count above list depth");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_INS_SH || state_q == S_INS_PUT || state_q == S_DEL_SH))
		else $error("list write outside a move or insert step");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req.ready)
		else $error("request taken while busy");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && status_q == ST_FULL) |-> cnt_x == CMP_W'(LIST_DEPTH))
		else $error("full status with room left");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_PUT) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the list");

endmodule

// ===== tb/positional_list_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Self-checking bench for the positional list engine. Requests are driven on
// the request channel and an in-bench list model predicts status, read value
// and entry count for each one. Every response is compared field by field
// with the oldest prediction. Directed cases cover the edges of the position
// range, the full list and clear. Random phases build and drain the list under
// varied sender gaps and receiver stalls, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
	import ple_pkg::*;

	localparam int LIST_DEPTH     = 64;
	localparam int TAIL_CYCLES    = LIST_DEPTH + 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF       = 300;

	typedef struct {
		status_t                 status;
		logic signed [VAL_W-1:0] value;
		logic [CNT_OUT_W-1:0]    count;
	} list_result_t;

	logic clk;
	logic arst_n;

	ple_req_if req_ch ();
	ple_rsp_if rsp_ch ();

	positional_list_engine #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic signed [VAL_W-1:0] list_model [LIST_DEPTH];
	int                      list_model_count;
	bit                      list_growing;
	list_result_t            expected_results [$];
	list_result_t            expected_head;
	int                      error_count;
	int                      send_idle_pct;
	int                      rsp_stall_pct;
	int                      rsp_hold_cycles;
	int                      quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		error_count++;
	endtask

	function automatic list_result_t apply_request(input req_type_t rt,
			input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] v);
		list_result_t res;
		int p;
		p = pos;
		res.status = ST_DONE;
		res.value  = '0;
		case (rt)
			REQ_INSERT: begin
				if (p == 0 || p > list_model_count + 1) begin
					res.status = ST_RANGE;
				end else if (list_model_count >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (int k = list_model_count; k >= p; k--)
						list_model[k] = list_model[k-1];
					list_model[p-1] = v;
					list_model_count++;
				end
			end
			REQ_READ: begin
				if (p == 0 || p > list_model_count)
					res.status = ST_RANGE;
				else
					res.value = list_model[p-1];
			end
			REQ_DELETE: begin
				if (p == 0 || p > list_model_count) begin
					res.status = ST_RANGE;
				end else begin
					for (int k = p; k < list_model_count; k++)
						list_model[k-1] = list_model[k];
					list_model_count--;
				end
			end
			default: begin
				list_model_count = 0;
			end
		endcase
		res.count = CNT_OUT_W'(list_model_count);
		return res;
	endfunction

	// valid stays high between back-to-back requests, lowered only for a gap
	task automatic send_request(input req_type_t rt, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= rt;
		req_ch.position <= pos;
		req_ch.in_value <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_results.push_back(apply_request(rt, pos, v));
	endtask

	function automatic logic signed [VAL_W-1:0] random_value();
		logic signed [VAL_W-1:0] v;
		v = $urandom;
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: v = 32'sh8000_0000;
				1: v = 32'sh7fff_ffff;
				2: v = '0;
				default: v = -1;
			endcase
		end
		return v;
	endfunction

	// mostly in-range traffic that sweeps the list between empty and full
	task automatic send_random_request();
		req_type_t rt;
		int        r;
		int        q;
		int        p;
		int        ins_pct;
		int        del_pct;
		r = $urandom_range(999);
		if (list_model_count == LIST_DEPTH && $urandom_range(7) == 0)
			list_growing = 1'b0;
		if (list_model_count == 0)
			list_growing = 1'b1;
		if (r < 2) begin
			rt = REQ_CLEAR;
			p  = $urandom_range(255);
		end else if (r < 60) begin
			rt = req_type_t'($urandom_range(2));
			p  = $urandom_range(255);
		end else if (r < 110) begin
			rt = req_type_t'($urandom_range(2));
			if ($urandom_range(3) == 0)
				p = 0;
			else if (rt == REQ_INSERT)
				p = $urandom_range(255, list_model_count + 2);
			else
				p = $urandom_range(255, list_model_count + 1);
		end else begin
			q       = $urandom_range(99);
			ins_pct = list_growing ? 55 : 15;
			del_pct = list_growing ? 15 : 55;
			if (q < ins_pct || list_model_count == 0) begin
				rt = REQ_INSERT;
				p  = $urandom_range(list_model_count + 1, 1);
			end else if (q < ins_pct + del_pct) begin
				rt = REQ_DELETE;
				p  = $urandom_range(list_model_count, 1);
			end else begin
				rt = REQ_READ;
				p  = $urandom_range(list_model_count, 1);
			end
		end
		send_request(rt, POS_W'(p), random_value());
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		send_request(REQ_CLEAR, 8'd0, $urandom);
		send_request(REQ_READ, 8'd1, $urandom);
		send_request(REQ_DELETE, 8'd1, $urandom);
		send_request(REQ_INSERT, 8'd0, $urandom);
		send_request(REQ_INSERT, 8'd2, $urandom);
		send_request(REQ_INSERT, 8'd1, 32'sh8000_0000);
		send_request(REQ_INSERT, 8'd2, 32'sh7fff_ffff);
		send_request(REQ_INSERT, 8'd1, -32'sd1);
		send_request(REQ_INSERT, 8'd2, 32'sd0);
		send_request(REQ_READ, 8'd0, $urandom);
		for (int i = 1; i <= 5; i++)
			send_request(REQ_READ, POS_W'(i), $urandom);
		send_request(REQ_DELETE, 8'd5, $urandom);
		send_request(REQ_DELETE, 8'd2, $urandom);
		send_request(REQ_DELETE, 8'd3, $urandom);
		send_request(REQ_INSERT, 8'd255, $urandom);
		send_request(REQ_READ, 8'd255, $urandom);
		send_request(REQ_DELETE, 8'd0, $urandom);
		send_request(REQ_READ, 8'd2, $urandom);
		send_request(REQ_CLEAR, 8'd255, $urandom);
		send_request(REQ_READ, 8'd1, $urandom);
		send_request(REQ_INSERT, 8'd1, 32'sh5555_5555);
	endtask

	task automatic test_full_list();
		send_idle_pct = 20;
		rsp_stall_pct = 20;
		send_request(REQ_CLEAR, 8'd7, $urandom);
		for (int i = 0; i < LIST_DEPTH; i++)
			send_request(REQ_INSERT, POS_W'($urandom_range(i + 1, 1)), random_value());
		send_request(REQ_INSERT, POS_W'(LIST_DEPTH + 1), $urandom);
		send_request(REQ_INSERT, 8'd1, $urandom);
		send_request(REQ_INSERT, POS_W'(LIST_DEPTH + 2), $urandom);
		send_request(REQ_READ, POS_W'(LIST_DEPTH), $urandom);
		send_request(REQ_READ, POS_W'(LIST_DEPTH + 1), $urandom);
		send_request(REQ_DELETE, POS_W'(LIST_DEPTH + 1), $urandom);
		send_request(REQ_DELETE, POS_W'(LIST_DEPTH), $urandom);
		send_request(REQ_INSERT, POS_W'(LIST_DEPTH), 32'sh1234_5678);
		send_request(REQ_READ, POS_W'(LIST_DEPTH), $urandom);
		send_request(REQ_DELETE, 8'd1, $urandom);
		send_request(REQ_READ, 8'd1, $urandom);
	endtask

	task automatic test_random(input int n, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (n)
			send_random_request();
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		@(posedge clk);
		rsp_hold_cycles = HOLD_OFF;
		repeat (20)
			send_random_request();
	endtask

	always @(negedge clk) begin
		if (rsp_hold_cycles > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold_cycles--;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				expected_head = expected_results.pop_front();
				if (rsp_ch.status !== expected_head.status)
					report_mismatch($sformatf("status expected %0d got %0d",
						expected_head.status, rsp_ch.status));
				if (rsp_ch.out_value !== expected_head.value)
					report_mismatch($sformatf("out_value expected %0d got %0d",
						expected_head.value, rsp_ch.out_value));
				if (rsp_ch.list_count !== expected_head.count)
					report_mismatch($sformatf("list_count expected %0d got %0d",
						expected_head.count, rsp_ch.list_count));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_CLEAR;
		req_ch.position  = '0;
		req_ch.in_value  = '0;
		rsp_ch.ready     = 1'b0;
		list_model_count = 0;
		list_growing     = 1'b1;
		error_count      = 0;
		send_idle_pct    = 0;
		rsp_stall_pct    = 0;
		rsp_hold_cycles  = 0;
		quiet_cycles     = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_list();
		test_random(300, 0, 0);
		test_random(300, 59, 0);
		test_random(300, 0, 59);
		test_random(300, 7, 7);
		test_backpressure();

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ple_pkg.sv
rtl/ple_req_if.sv
rtl/ple_rsp_if.sv
rtl/ple_ram.sv
rtl/positional_list_engine.sv
tb/positional_list_engine_tb.sv
